// ===== src/lsw_pkg.sv =====
// Package for the segment-LCD serial writer: item types, opcodes and sizing.
// Used by lsw_out_queue and lcd_segment_serial_writer; depends on nothing.
package lsw_pkg;

    // Display memory size and the index width that addresses it
    localparam int SEGMENTS = 32;
    localparam int SEG_IW   = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;

    localparam int CMD_BITS    = 12;
    localparam int HDR_BITS    = 9;
    localparam int NIB_BITS    = 4;
    localparam logic [8:0] HEADER_RESET = 9'd320;

    // APB byte address of the frame header register
    localparam logic [0:0] REG_FRAME_HEADER = 1'b0;

    // Input operation codes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_CMD   = 2'd2;
    localparam logic [1:0] OP_FRAME = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [4:0]  seg_index;
        logic [3:0]  nibble;
        logic [11:0] command_word;
    } t_in_item;

    typedef struct packed {
        logic select_pin;
        logic clock_pin;
        logic data_pin;
        logic busy_res;
        logic done_res;
    } t_out_item;

endpackage

// ===== src/lsw_out_queue.sv =====
// Two-entry result queue between the tick engine and the output channel.
// Depends on lsw_pkg for the result item type.
module lsw_out_queue
    import lsw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_item,
    output logic      o_full,
    output logic      o_valid,
    output t_out_item o_data,
    input  logic      i_stall
);

    t_out_item  r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_pop;

    assign w_pop   = (r_count != 2'd0) && !i_stall;
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ===== src/lcd_segment_serial_writer.sv =====
// Top level of the three-wire segment-LCD serial writer: tick engine,
// display memory, APB header register. Depends on lsw_pkg and lsw_out_queue.
//
// Every accepted input transaction is one half-bit tick of the serial line
// and yields exactly one result transaction carrying the pin levels after
// that tick plus busy and done flags. The engine takes one transaction per
// clock: the whole tick (display write, sequencer step, pin update) is a
// single pass of logic between the state registers, and results go into a
// two-entry queue, so input is stalled only while that queue is full. A
// command start sends 12 bits MSB first; a frame start sends the 9-bit
// frame_header (APB register at address 0, sampled at frame start) MSB
// first, then each of the SEGMENTS display nibbles LSB first. Each bit is
// two ticks (clock low with data, then clock high); select falls on the
// start tick, and the close takes two ticks: select high, then clock and
// data high with done set. Starts while busy are ignored; nibble writes are
// taken at any time and a nibble loaded on the same tick sees the new value.
module lcd_segment_serial_writer
    import lsw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    input  t_in_item    i_data,
    output logic        o_stall,
    // result channel
    output logic        o_valid,
    output t_out_item   o_data,
    input  logic        i_stall,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_LOW_MSB    = 3'd1,
        PH_HIGH_MSB   = 3'd2,
        PH_LOW_LSB    = 3'd3,
        PH_HIGH_LSB   = 3'd4,
        PH_CLOSE_SEL  = 3'd5,
        PH_CLOSE_IDLE = 3'd6
    } t_phase;

    t_phase         r_phase,  n_phase;
    logic [11:0]    r_shift,  n_shift;
    logic [3:0]     r_bits,   n_bits;
    logic [5:0]     r_ptr,    n_ptr;
    logic           r_kind,   n_kind;
    logic           r_sel,    n_sel;
    logic           r_clk,    n_clk;
    logic           r_dat,    n_dat;
    logic [3:0]     r_store [SEGMENTS];
    logic [3:0]     n_store [SEGMENTS];
    logic [8:0]     r_header;

    logic           w_push;
    logic           w_busy;
    logic           w_done;
    logic [6:0]     w_wr_idx;
    logic [6:0]     w_next_idx;
    logic [3:0]     w_first_nib;
    logic [3:0]     w_next_nib;
    logic           w_cfg_wr;
    t_out_item      w_result;

    // APB: one register, always ready; a write to its address lands on frame_header
    assign pready   = 1'b1;
    assign prdata   = {23'd0, r_header};
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr == REG_FRAME_HEADER);

    assign w_push     = i_valid && !o_stall;
    assign w_wr_idx   = {2'd0, i_data.seg_index};
    assign w_next_idx = {1'b0, r_ptr} + 7'd1;

    // Apply the display write first so a nibble loaded this tick sees it
    always_comb begin
        for (int k = 0; k < SEGMENTS; k++) begin
            n_store[k] = r_store[k];
        end
        if (i_data.operation == OP_WRITE && w_wr_idx < 7'(SEGMENTS)) begin
            n_store[w_wr_idx[SEG_IW-1:0]] = i_data.nibble;
        end
    end

    assign w_first_nib = n_store[0];
    assign w_next_nib  = (w_next_idx < 7'(SEGMENTS)) ? n_store[w_next_idx[SEG_IW-1:0]]
                                                     : 4'd0;

    // Sequencer step for one tick
    always_comb begin
        n_phase = r_phase;
        n_shift = r_shift;
        n_bits  = r_bits;
        n_ptr   = r_ptr;
        n_kind  = r_kind;
        n_sel   = r_sel;
        n_clk   = r_clk;
        n_dat   = r_dat;
        w_busy  = 1'b1;
        w_done  = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                w_busy = 1'b0;
                if (i_data.operation == OP_CMD || i_data.operation == OP_FRAME) begin
                    n_kind  = (i_data.operation == OP_FRAME);
                    if (i_data.operation == OP_CMD) begin
                        n_shift = i_data.command_word;
                        n_bits  = 4'(CMD_BITS);
                    end else begin
                        n_shift = {r_header, 3'd0};
                        n_bits  = 4'(HDR_BITS);
                    end
                    n_ptr   = 6'd0;
                    n_sel   = 1'b0;
                    n_phase = PH_LOW_MSB;
                    w_busy  = 1'b1;
                end
            end
            PH_LOW_MSB: begin
                n_clk   = 1'b0;
                n_dat   = r_shift[11];
                n_phase = PH_HIGH_MSB;
            end
            PH_HIGH_MSB: begin
                n_clk   = 1'b1;
                n_shift = {r_shift[10:0], 1'b0};
                n_bits  = r_bits - 4'd1;
                if (r_bits == 4'd1) begin
                    if (r_kind) begin
                        // header done: load the first nibble
                        n_ptr   = 6'd0;
                        n_shift = {8'd0, w_first_nib};
                        n_bits  = 4'(NIB_BITS);
                        n_phase = PH_LOW_LSB;
                    end else begin
                        n_phase = PH_CLOSE_SEL;
                    end
                end else begin
                    n_phase = PH_LOW_MSB;
                end
            end
            PH_LOW_LSB: begin
                n_clk   = 1'b0;
                n_dat   = r_shift[0];
                n_phase = PH_HIGH_LSB;
            end
            PH_HIGH_LSB: begin
                n_clk   = 1'b1;
                n_shift = {1'b0, r_shift[11:1]};
                n_bits  = r_bits - 4'd1;
                if (r_bits == 4'd1) begin
                    if (w_next_idx < 7'(SEGMENTS)) begin
                        // advance to the next display entry
                        n_ptr   = w_next_idx[5:0];
                        n_shift = {8'd0, w_next_nib};
                        n_bits  = 4'(NIB_BITS);
                        n_phase = PH_LOW_LSB;
                    end else begin
                        n_phase = PH_CLOSE_SEL;
                    end
                end else begin
                    n_phase = PH_LOW_LSB;
                end
            end
            PH_CLOSE_SEL: begin
                n_sel   = 1'b1;
                n_phase = PH_CLOSE_IDLE;
            end
            PH_CLOSE_IDLE: begin
                n_clk   = 1'b1;
                n_dat   = 1'b1;
                n_phase = PH_IDLE;
                w_done  = 1'b1;
            end
            default: begin
                n_phase = PH_IDLE;
                w_busy  = 1'b0;
            end
        endcase
    end

    assign w_result = '{select_pin: n_sel, clock_pin: n_clk, data_pin: n_dat,
                        busy_res: w_busy, done_res: w_done};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_shift  <= 12'd0;
            r_bits   <= 4'd0;
            r_ptr    <= 6'd0;
            r_kind   <= 1'b0;
            r_sel    <= 1'b1;
            r_clk    <= 1'b1;
            r_dat    <= 1'b1;
            r_header <= HEADER_RESET;
            for (int k = 0; k < SEGMENTS; k++) begin
                r_store[k] <= 4'd0;
            end
        end else begin
            if (w_cfg_wr) begin
                r_header <= pwdata[8:0];
            end
            if (w_push) begin
                r_phase <= n_phase;
                r_shift <= n_shift;
                r_bits  <= n_bits;
                r_ptr   <= n_ptr;
                r_kind  <= n_kind;
                r_sel   <= n_sel;
                r_clk   <= n_clk;
                r_dat   <= n_dat;
                for (int k = 0; k < SEGMENTS; k++) begin
                    r_store[k] <= n_store[k];
                end
            end
        end
    end

    lsw_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_result),
        .o_full  (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    // A full queue always has a result on offer
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result pending");

    // Nibble phases occur only inside a frame transfer
    a_nibble_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LOW_LSB || r_phase == PH_HIGH_LSB) |-> r_kind)
        else $error("nibble phase during a command transfer");

    // Closing tick raises select
    a_close_raises_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && r_phase == PH_CLOSE_SEL) |=> (r_sel && r_phase == PH_CLOSE_IDLE))
        else $error("select not raised on close");

    // Bit count never exceeds the command length
    a_bits_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bits <= 4'(CMD_BITS))
        else $error("bit count out of range");

endmodule

// ===== verif/lcd_segment_serial_writer_tb.sv =====
// Self-checking testbench for the three-wire segment-LCD serial writer.
// Predicts pin levels per tick in-bench and checks every result transaction;
// depends on lsw_pkg and the lcd_segment_serial_writer RTL only.
module lcd_segment_serial_writer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lsw_pkg::*;

    // Sequencer phases of the predicted serial line
    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_LOW_MSB,
        SQ_HIGH_MSB,
        SQ_LOW_LSB,
        SQ_HIGH_LSB,
        SQ_CLOSE_SEL,
        SQ_CLOSE_IDLE
    } t_line_phase;

    localparam logic [0:0] HDR_ADDR      = REG_FRAME_HEADER;
    localparam int         IDLE_PCT      = 22;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         HOLD_CYCLES   = 64;
    localparam int         MAX_REPORTS   = 10;
    localparam int         IN_W          = $bits(t_in_item);

    // DUT-facing signals; the inputs driven by the bench are known from time zero
    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    t_in_item    i_data  = '0;
    logic        o_stall;
    logic        o_valid;
    t_out_item   o_data;
    logic        i_stall = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [0:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Predicted state of the serial line
    logic [3:0]  seg_mem [SEGMENTS];
    logic [11:0] shreg;
    logic [3:0]  bits_rem;
    logic [5:0]  nib_ptr;
    t_line_phase phase;
    logic        sending_frame;
    logic        pin_sel, pin_clk, pin_dat;
    logic [8:0]  hdr_reg;

    // Pin levels still owed by the block, oldest first
    t_out_item   pin_levels_due[$];

    // Traffic shaping shared with the result sink; hold_request counts the
    // long hold-offs asked of the sink so far
    bit          no_idle      = 1'b0;
    int          hold_request = 0;

    int          items_sent     = 0;
    int          results_seen   = 0;
    int          cmds_started   = 0;
    int          frames_started = 0;
    int          header_writes  = 0;
    int          fail_count     = 0;

    lcd_segment_serial_writer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: end a hung run well past the slowest legal one
    initial begin
        #1_000_000;
        $display("[lcd_segment_serial_writer] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Point the shifter at one display nibble, sent LSB first
    function automatic void load_entry(input int k);
        nib_ptr  = k[5:0];
        shreg    = {8'h00, seg_mem[k % SEGMENTS]};
        bits_rem = 4'(NIB_BITS);
        phase    = SQ_LOW_LSB;
    endfunction

    // Advance the predicted line by one tick and return the pins it leaves
    function automatic t_out_item advance_line(input t_in_item it);
        t_out_item r;
        logic      busy;
        logic      done;
        busy = 1'b0;
        done = 1'b0;
        // Writes land before the sequencer moves, so a same-tick load sees them
        if (it.operation == OP_WRITE && int'(it.seg_index) < SEGMENTS) begin
            seg_mem[it.seg_index] = it.nibble;
        end
        case (phase)
            SQ_IDLE: begin
                if (it.operation == OP_CMD || it.operation == OP_FRAME) begin
                    sending_frame = (it.operation == OP_FRAME);
                    if (sending_frame) begin
                        shreg    = {hdr_reg, 3'b000};
                        bits_rem = 4'(HDR_BITS);
                        frames_started++;
                    end else begin
                        shreg    = it.command_word;
                        bits_rem = 4'(CMD_BITS);
                        cmds_started++;
                    end
                    nib_ptr = '0;
                    pin_sel = 1'b0;
                    phase   = SQ_LOW_MSB;
                    busy    = 1'b1;
                end
            end
            SQ_LOW_MSB: begin
                pin_clk = 1'b0;
                pin_dat = shreg[11];
                phase   = SQ_HIGH_MSB;
                busy    = 1'b1;
            end
            SQ_HIGH_MSB: begin
                pin_clk  = 1'b1;
                shreg    = shreg << 1;
                bits_rem = bits_rem - 4'd1;
                if (bits_rem == 4'd0) begin
                    if (sending_frame) begin
                        load_entry(0);
                    end else begin
                        phase = SQ_CLOSE_SEL;
                    end
                end else begin
                    phase = SQ_LOW_MSB;
                end
                busy = 1'b1;
            end
            SQ_LOW_LSB: begin
                pin_clk = 1'b0;
                pin_dat = shreg[0];
                phase   = SQ_HIGH_LSB;
                busy    = 1'b1;
            end
            SQ_HIGH_LSB: begin
                pin_clk  = 1'b1;
                shreg    = shreg >> 1;
                bits_rem = bits_rem - 4'd1;
                if (bits_rem == 4'd0) begin
                    if (int'(nib_ptr) + 1 < SEGMENTS) begin
                        load_entry(int'(nib_ptr) + 1);
                    end else begin
                        phase = SQ_CLOSE_SEL;
                    end
                end else begin
                    phase = SQ_LOW_LSB;
                end
                busy = 1'b1;
            end
            SQ_CLOSE_SEL: begin
                pin_sel = 1'b1;
                phase   = SQ_CLOSE_IDLE;
                busy    = 1'b1;
            end
            SQ_CLOSE_IDLE: begin
                pin_clk = 1'b1;
                pin_dat = 1'b1;
                phase   = SQ_IDLE;
                busy    = 1'b1;
                done    = 1'b1;
            end
            default: begin
                phase = SQ_IDLE;
            end
        endcase
        r.select_pin = pin_sel;
        r.clock_pin  = pin_clk;
        r.data_pin   = pin_dat;
        r.busy_res   = busy;
        r.done_res   = done;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Fill every field at random, then force the operation
    function automatic t_in_item make_item(input logic [1:0] op);
        t_in_item it;
        it           = t_in_item'(IN_W'($urandom));
        it.operation = op;
        return it;
    endfunction

    function automatic t_in_item write_item(input logic [4:0] idx, input logic [3:0] nib);
        t_in_item it;
        it           = make_item(OP_WRITE);
        it.seg_index = idx;
        it.nibble    = nib;
        return it;
    endfunction

    // Mostly plain ticks while a transfer runs, with writes and ignored starts
    function automatic logic [1:0] busy_noise_op();
        int r;
        r = $urandom_range(99);
        if (r < 65) return OP_TICK;
        if (r < 90) return OP_WRITE;
        if (r < 95) return OP_CMD;
        return OP_FRAME;
    endfunction

    // Offer one transaction and predict it at its acceptance edge. Return in
    // the acceptance time step with valid still high: the caller either sends
    // again or drops valid in that same step.
    task automatic send_item(input t_in_item it);
        int gap;
        gap = 0;
        if (!no_idle) begin
            while ($urandom_range(99) < IDLE_PCT) gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (o_stall);
        pin_levels_due.push_back(advance_line(it));
        items_sent++;
    endtask

    // Tick until the predicted transfer has closed
    task automatic finish_transfer(input bit noisy);
        while (phase != SQ_IDLE) begin
            send_item(make_item(noisy ? busy_noise_op() : OP_TICK));
        end
    endtask

    task automatic run_transfer(input t_in_item start, input bit noisy);
        send_item(start);
        finish_transfer(noisy);
    endtask

    // Drop valid, wait for every owed result, then let the block settle
    task automatic wait_results_done();
        i_valid <= 1'b0;
        while (pin_levels_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup then access phase; the register takes the value at the access edge
    task automatic write_header(input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= HDR_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        hdr_reg = value[8:0];
        header_writes++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Pins must sit high with busy and done low out of reset
    task automatic test_idle_after_reset();
        repeat (3) send_item(make_item(OP_TICK));
    endtask

    // Extreme indexes and nibbles, then a frame that shifts them out
    task automatic test_segment_extremes();
        send_item(write_item(5'd0, 4'hF));
        send_item(write_item(5'd31, 4'hF));
        send_item(write_item(5'd1, 4'h0));
        send_item(write_item(5'd30, 4'h0));
        send_item(write_item(5'd31, 4'h0));
        run_transfer(make_item(OP_FRAME), 1'b0);
    endtask

    // All-ones, all-zeros and edge-bit command words; starts while busy
    task automatic test_command_words();
        t_in_item it;
        logic [11:0] words [3];
        words = '{12'hFFF, 12'h000, 12'h801};
        foreach (words[k]) begin
            it = make_item(OP_CMD);
            it.command_word = words[k];
            run_transfer(it, 1'b0);
        end
        // Both start kinds mid-transfer must be ignored, ticks still advance
        it = make_item(OP_CMD);
        it.command_word = 12'h5A5;
        send_item(it);
        send_item(make_item(OP_FRAME));
        send_item(make_item(OP_CMD));
        send_item(write_item(5'd7, 4'h9));
        finish_transfer(1'b0);
    endtask

    // Rewrite each nibble on the very tick it is loaded into the shifter
    task automatic test_load_tick_writes();
        t_in_item it;
        send_item(make_item(OP_FRAME));
        while (phase != SQ_IDLE) begin
            if (phase == SQ_HIGH_MSB && bits_rem == 4'd1 && sending_frame) begin
                it = write_item(5'd0, 4'($urandom));
            end else if (phase == SQ_HIGH_LSB && bits_rem == 4'd1) begin
                it = write_item(5'(nib_ptr + 6'd1), 4'($urandom));
            end else begin
                it = make_item(OP_TICK);
            end
            send_item(it);
        end
    endtask

    // Header extremes, upper write bits random
    task automatic test_header_settings();
        logic [8:0] headers [2];
        headers = '{9'h000, 9'h1FF};
        foreach (headers[k]) begin
            wait_results_done();
            write_header({23'($urandom), headers[k]});
            run_transfer(make_item(OP_FRAME), 1'b0);
        end
    endtask

    // Hold the result side long enough to fill the block and stall its input
    task automatic test_result_backpressure();
        wait_results_done();
        hold_request++;
        send_item(make_item(OP_CMD));
        repeat (40) send_item(make_item(busy_noise_op()));
        finish_transfer(1'b1);
        // Pause the sender until everything owed has come back
        wait_results_done();
    endtask

    // Mostly complete transfers with random content, plus bursts and noise
    task automatic test_random_traffic(input int count, input bit calm, input logic [8:0] hdr);
        int target;
        int r;
        wait_results_done();
        write_header({23'($urandom), hdr});
        no_idle = calm;
        target  = items_sent + count;
        while (items_sent < target) begin
            r = $urandom_range(99);
            if (r < 40) begin
                run_transfer(make_item(OP_CMD), 1'b1);
            end else if (r < 52) begin
                run_transfer(make_item(OP_FRAME), 1'b1);
            end else if (r < 78) begin
                repeat ($urandom_range(1, 8)) send_item(make_item(OP_WRITE));
            end else begin
                repeat ($urandom_range(1, 6)) send_item(make_item(2'($urandom)));
            end
        end
        finish_transfer(1'b1);
        wait_results_done();
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Stall at random, hold off on request, or stay open in calm stretches
    initial begin : result_sink
        int hold_left;
        int holds_taken;
        hold_left   = 0;
        holds_taken = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request != holds_taken) begin
                hold_left   = HOLD_CYCLES;
                holds_taken = hold_request;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else if (no_idle) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Compare each accepted result with the oldest owed pin levels
    always @(posedge i_clk) begin : compare_pins
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pin_levels_due.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("t=%0t unexpected result sel=%b clk=%b dat=%b busy=%b done=%b",
                             $realtime, o_data.select_pin, o_data.clock_pin,
                             o_data.data_pin, o_data.busy_res, o_data.done_res);
                end
            end else begin
                want = pin_levels_due.pop_front();
                if (o_data.select_pin !== want.select_pin ||
                    o_data.clock_pin  !== want.clock_pin  ||
                    o_data.data_pin   !== want.data_pin   ||
                    o_data.busy_res   !== want.busy_res   ||
                    o_data.done_res   !== want.done_res) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $write("t=%0t result %0d: expected sel=%b clk=%b dat=%b busy=%b done=%b",
                               $realtime, results_seen,
                               want.select_pin, want.clock_pin, want.data_pin,
                               want.busy_res, want.done_res);
                        $display(", got sel=%b clk=%b dat=%b busy=%b done=%b",
                                 o_data.select_pin, o_data.clock_pin, o_data.data_pin,
                                 o_data.busy_res, o_data.done_res);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        // Start the predictor from the reset state
        foreach (seg_mem[k]) seg_mem[k] = 4'h0;
        shreg         = '0;
        bits_rem      = '0;
        nib_ptr       = '0;
        phase         = SQ_IDLE;
        sending_frame = 1'b0;
        pin_sel       = 1'b1;
        pin_clk       = 1'b1;
        pin_dat       = 1'b1;
        hdr_reg       = HEADER_RESET;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_after_reset();
        test_segment_extremes();
        test_command_words();
        test_load_tick_writes();
        test_header_settings();
        test_result_backpressure();
        test_random_traffic(200, 1'b0, 9'h0AA);
        test_random_traffic(150, 1'b1, 9'h155);

        // Drain, then allow a tail for any stray result
        wait_results_done();
        repeat (16) @(posedge i_clk);
        if (pin_levels_due.size() != 0) begin
            fail_count++;
            $display("%0d results never arrived", pin_levels_due.size());
        end

        $display("Covered %0d input transactions and %0d results: %0d commands, %0d frames,",
                 items_sent, results_seen, cmds_started, frames_started);
        $display("%0d header writes, a long result hold-off and a no-idle stretch; %0d failures.",
                 header_writes, fail_count);
        if (fail_count == 0) begin
            $display("[lcd_segment_serial_writer] OK");
        end else begin
            $display("[lcd_segment_serial_writer] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/lsw_pkg.sv
src/lsw_out_queue.sv
src/lcd_segment_serial_writer.sv
verif/lcd_segment_serial_writer_tb.sv
